// ===== rtl/crfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfp_pkg
// Shared types and constants of the camera reply frame parser.
// ----------------------------------------------------------------------------
package crfp_pkg;

    localparam int CHUNK_SIZE_DEF   = 512;
    localparam int CAMERA_SLOTS_DEF = 4;
    localparam int REPLY_DEPTH_DEF  = 8;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [7:0] CH_SYNC  = 8'h55; // 'U'
    localparam logic [7:0] CH_IMAGE = 8'h46; // 'F'
    localparam logic [7:0] CH_END   = 8'h23; // '#'
    localparam logic [7:0] CH_SNAP  = 8'h52; // 'R'
    localparam logic [7:0] CH_ECHO  = 8'h43; // 'C'
    localparam logic [7:0] CH_NAK   = 8'h3F; // '?'
    localparam logic [7:0] CH_ACK_H = 8'h48; // 'H'
    localparam logic [7:0] CH_ACK_E = 8'h45; // 'E'
    localparam logic [7:0] CH_ACK_D = 8'h44; // 'D'
    localparam logic [7:0] CH_ACK_Q = 8'h51; // 'Q'

    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_PACKET = 2'd1;
    localparam logic [1:0] ACT_REPLY  = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] EV_DATA   = 2'd0;
    localparam logic [1:0] EV_PACKET = 2'd1;
    localparam logic [1:0] EV_REPLY  = 2'd2;

    localparam logic [2:0] REPLY_NONE = 3'd0;
    localparam logic [2:0] REPLY_ACK  = 3'd1;
    localparam logic [2:0] REPLY_NAK  = 3'd2;
    localparam logic [2:0] REPLY_SNAP = 3'd3;
    localparam logic [2:0] REPLY_ECHO = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  camera;
        logic [7:0]  command;
        logic [15:0] packet_id;
        logic [7:0]  data_byte;
        logic [8:0]  data_index;
        logic [15:0] data_len;
        logic        checksum_ok;
        logic [31:0] snap_size;
        logic [15:0] snap_count;
    } t_action;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  camera_id;
        logic [7:0]  command;
        logic [2:0]  reply;
        logic [15:0] packet_id;
        logic [15:0] packet_count;
        logic [15:0] data_len;
        logic [31:0] byte_offset;
        logic [31:0] file_size;
        logic [7:0]  data_byte;
        logic [8:0]  data_index;
        logic        checksum_ok;
    } t_result;

endpackage

// ===== rtl/crfp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfp_fifo
// Small register queue, first word out on o_data while not empty.
// ----------------------------------------------------------------------------
module crfp_fifo
    import crfp_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(FIFO_DEPTH);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/crfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfp_front
// Byte parser: walks the frame phases and issues actions to the back end.
// ----------------------------------------------------------------------------
module crfp_front
    import crfp_pkg::*;
#(
    parameter int CHUNK_SIZE  = CHUNK_SIZE_DEF,
    parameter int REPLY_DEPTH = REPLY_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_act_push,
    output t_action    o_act
);
    localparam int RIW = $clog2(REPLY_DEPTH);

    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_CMD     = 4'd1;
    localparam logic [3:0] PH_CAM     = 4'd2;
    localparam logic [3:0] PH_CMDDATA = 4'd3;
    localparam logic [3:0] PH_PID0    = 4'd4;
    localparam logic [3:0] PH_PID1    = 4'd5;
    localparam logic [3:0] PH_LEN0    = 4'd6;
    localparam logic [3:0] PH_LEN1    = 4'd7;
    localparam logic [3:0] PH_DATA    = 4'd8;
    localparam logic [3:0] PH_CRC0    = 4'd9;
    localparam logic [3:0] PH_CRC1    = 4'd10;

    logic        r_halted;
    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_camera, n_camera;
    logic [15:0] r_packet, n_packet;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_rx_sum_lo, n_rx_sum_lo;
    logic [7:0]  r_reply_data [REPLY_DEPTH];
    logic        reply_we;
    logic [15:0] count_inc;
    logic        active;

    assign active    = i_valid && !i_kind && !r_halted;
    assign count_inc = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_command   = r_command;
        n_camera    = r_camera;
        n_packet    = r_packet;
        n_length    = r_length;
        n_count     = r_count;
        n_rx_sum_lo = r_rx_sum_lo;
        reply_we    = 1'b0;
        o_act_push  = 1'b0;
        o_act       = '0;
        o_act.camera     = r_camera;
        o_act.command    = r_command;
        o_act.packet_id  = r_packet;
        o_act.data_byte  = i_rx_byte;
        o_act.data_index = r_count[8:0];
        o_act.data_len   = r_count;
        o_act.checksum_ok = (r_sum == {i_rx_byte, r_rx_sum_lo});
        o_act.snap_size  = {r_reply_data[3], r_reply_data[2], r_reply_data[1],
                            r_reply_data[0]};
        o_act.snap_count = {r_reply_data[5], r_reply_data[4]};

        if (i_valid && i_kind) begin
            o_act_push = 1'b1;
            o_act.kind = ACT_CLEAR;
        end else if (active) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_rx_byte == CH_SYNC) begin
                        n_sum   = {8'd0, i_rx_byte};
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_sum     = r_sum + {8'd0, i_rx_byte};
                    n_command = i_rx_byte;
                    n_count   = '0;
                    n_phase   = PH_CAM;
                end
                PH_CAM: begin
                    n_sum    = r_sum + {8'd0, i_rx_byte};
                    n_camera = i_rx_byte;
                    n_count  = '0;
                    n_phase  = (r_command == CH_IMAGE) ? PH_PID0 : PH_CMDDATA;
                end
                PH_CMDDATA: begin
                    if (i_rx_byte == CH_END) begin
                        o_act_push = 1'b1;
                        o_act.kind = ACT_REPLY;
                        n_phase    = PH_HEADER;
                    end else if (r_count < 16'(REPLY_DEPTH)) begin
                        reply_we = 1'b1;
                        n_count  = r_count + 16'd1;
                    end
                end
                PH_PID0: begin
                    n_sum    = r_sum + {8'd0, i_rx_byte};
                    n_packet = {8'd0, i_rx_byte};
                    n_phase  = PH_PID1;
                end
                PH_PID1: begin
                    n_sum    = r_sum + {8'd0, i_rx_byte};
                    n_packet = {i_rx_byte, r_packet[7:0]};
                    n_phase  = PH_LEN0;
                end
                PH_LEN0: begin
                    n_sum    = r_sum + {8'd0, i_rx_byte};
                    n_length = {8'd0, i_rx_byte};
                    n_phase  = PH_LEN1;
                end
                PH_LEN1: begin
                    n_sum    = r_sum + {8'd0, i_rx_byte};
                    n_length = {i_rx_byte, r_length[7:0]};
                    n_count  = '0;
                    n_phase  = PH_DATA;
                end
                PH_DATA: begin
                    if (r_count < 16'(CHUNK_SIZE)) begin
                        n_sum      = r_sum + {8'd0, i_rx_byte};
                        o_act_push = 1'b1;
                        o_act.kind = ACT_DATA;
                    end
                    n_count = count_inc;
                    if (count_inc >= r_length) begin
                        n_phase = PH_CRC0;
                    end
                end
                PH_CRC0: begin
                    n_rx_sum_lo = i_rx_byte;
                    n_phase     = PH_CRC1;
                end
                PH_CRC1: begin
                    o_act_push = 1'b1;
                    o_act.kind = ACT_PACKET;
                    n_sum      = '0;
                    n_phase    = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted    <= 1'b0;
            r_phase     <= PH_HEADER;
            r_sum       <= '0;
            r_command   <= '0;
            r_camera    <= '0;
            r_packet    <= '0;
            r_length    <= '0;
            r_count     <= '0;
            r_rx_sum_lo <= '0;
        end else begin
            if (i_cfg_we) begin
                r_halted <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_command   <= n_command;
            r_camera    <= n_camera;
            r_packet    <= n_packet;
            r_length    <= n_length;
            r_count     <= n_count;
            r_rx_sum_lo <= n_rx_sum_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reply_we) begin
            r_reply_data[r_count[RIW-1:0]] <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/crfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfp_back
// Action executor: keeps the snapshot tables and builds result words.
// ----------------------------------------------------------------------------
module crfp_back
    import crfp_pkg::*;
#(
    parameter int CHUNK_SIZE   = CHUNK_SIZE_DEF,
    parameter int CAMERA_SLOTS = CAMERA_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_act_empty,
    input  t_action i_act,
    output logic    o_act_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);
    localparam int SW = (CAMERA_SLOTS > 1) ? $clog2(CAMERA_SLOTS) : 1;

    logic [31:0] r_size_tab  [CAMERA_SLOTS];
    logic [15:0] r_count_tab [CAMERA_SLOTS];
    logic        in_table;
    logic [SW-1:0] slot;
    logic        snap_we;
    logic [31:0] pid_m1;

    assign in_table  = (i_act.camera < 8'(CAMERA_SLOTS));
    assign slot      = i_act.camera[SW-1:0];
    assign o_act_pop = !i_act_empty && !i_res_full;
    assign pid_m1    = {16'd0, i_act.packet_id} - 32'd1;

    always_comb begin
        o_res_push = 1'b0;
        snap_we    = 1'b0;
        o_res      = '0;
        o_res.camera_id = i_act.camera;
        o_res.command   = i_act.command;
        case (i_act.kind)
            ACT_DATA: begin
                o_res_push       = o_act_pop;
                o_res.event_res  = EV_DATA;
                o_res.packet_id  = i_act.packet_id;
                o_res.data_byte  = i_act.data_byte;
                o_res.data_index = i_act.data_index;
            end
            ACT_PACKET: begin
                o_res_push        = o_act_pop;
                o_res.event_res   = EV_PACKET;
                o_res.packet_id   = i_act.packet_id;
                o_res.data_len    = i_act.data_len;
                o_res.byte_offset = 32'(pid_m1 * 32'(CHUNK_SIZE));
                o_res.checksum_ok = i_act.checksum_ok;
                if (in_table) begin
                    o_res.packet_count = r_count_tab[slot];
                    o_res.file_size    = r_size_tab[slot];
                end
            end
            ACT_REPLY: begin
                o_res_push      = o_act_pop;
                o_res.event_res = EV_REPLY;
                case (i_act.command)
                    CH_SNAP: begin
                        if (in_table) begin
                            snap_we            = o_act_pop;
                            o_res.reply        = REPLY_SNAP;
                            o_res.packet_count = i_act.snap_count;
                            o_res.file_size    = i_act.snap_size;
                        end
                    end
                    CH_ECHO:  o_res.reply = REPLY_ECHO;
                    CH_ACK_H: o_res.reply = REPLY_ACK;
                    CH_ACK_E: o_res.reply = REPLY_ACK;
                    CH_ACK_D: o_res.reply = REPLY_ACK;
                    CH_ACK_Q: o_res.reply = REPLY_ACK;
                    CH_NAK:   o_res.reply = REPLY_NAK;
                    default:  o_res.reply = REPLY_NONE;
                endcase
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAMERA_SLOTS; i++) begin
                r_size_tab[i]  <= '0;
                r_count_tab[i] <= '0;
            end
        end else if (o_act_pop && (i_act.kind == ACT_CLEAR)) begin
            for (int i = 0; i < CAMERA_SLOTS; i++) begin
                r_size_tab[i]  <= '0;
                r_count_tab[i] <= '0;
            end
        end else if (snap_we) begin
            r_size_tab[slot]  <= i_act.snap_size;
            r_count_tab[slot] <= i_act.snap_count;
        end
    end

endmodule

// ===== rtl/camera_reply_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_reply_frame_parser
// Serial camera reply parser with image packet and snapshot info handling.
// ----------------------------------------------------------------------------
// One word is taken every cycle while full is low. The parser decides per
// byte what happens and posts an action into a four-entry action queue; an
// executor holding the snapshot tables turns actions into result words in a
// four-entry result queue. A result passes both queues to the result ports,
// after the byte that causes it. full rises only when the action queue is
// full, which happens only when pop stays low long enough for both queues to
// fill. The table clear word acts even while halted.
// ----------------------------------------------------------------------------
module camera_reply_frame_parser
    import crfp_pkg::*;
#(
    parameter int CHUNK_SIZE   = CHUNK_SIZE_DEF,
    parameter int CAMERA_SLOTS = CAMERA_SLOTS_DEF,
    parameter int REPLY_DEPTH  = REPLY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_camera_id,
    output logic [7:0]  o_command,
    output logic [2:0]  o_reply,
    output logic [15:0] o_packet_id,
    output logic [15:0] o_packet_count,
    output logic [15:0] o_data_len,
    output logic [31:0] o_byte_offset,
    output logic [31:0] o_file_size,
    output logic [7:0]  o_data_byte,
    output logic [8:0]  o_data_index,
    output logic        o_checksum_ok
);
    logic    act_push, act_pop, act_empty;
    t_action act_in, act_out;
    logic    res_push, res_full;
    t_result res_in, res_out;

    crfp_front #(
        .CHUNK_SIZE  (CHUNK_SIZE),
        .REPLY_DEPTH (REPLY_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (push && !full),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .o_act_push (act_push),
        .o_act      (act_in)
    );

    crfp_fifo #(
        .WIDTH ($bits(t_action))
    ) u_act_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (act_push),
        .i_data  (act_in),
        .o_full  (full),
        .i_pop   (act_pop),
        .o_data  (act_out),
        .o_empty (act_empty)
    );

    crfp_back #(
        .CHUNK_SIZE   (CHUNK_SIZE),
        .CAMERA_SLOTS (CAMERA_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act_empty (act_empty),
        .i_act       (act_out),
        .o_act_pop   (act_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    crfp_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_event_res    = res_out.event_res;
    assign o_camera_id    = res_out.camera_id;
    assign o_command      = res_out.command;
    assign o_reply        = res_out.reply;
    assign o_packet_id    = res_out.packet_id;
    assign o_packet_count = res_out.packet_count;
    assign o_data_len     = res_out.data_len;
    assign o_byte_offset  = res_out.byte_offset;
    assign o_file_size    = res_out.file_size;
    assign o_data_byte    = res_out.data_byte;
    assign o_data_index   = res_out.data_index;
    assign o_checksum_ok  = res_out.checksum_ok;

endmodule
